[design/sdq_pkg.sv]
// Shared types, codes and default sizes for the sleep delta queue.
`timescale 1ns / 1ps
package sdq_pkg;

   // Default sizes of the queue.
   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_ID_WIDTH    = 16;
   localparam int DEF_DELAY_WIDTH = 32;

   // Request operation codes.
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_TICK   = 3'd1;
   localparam logic [2:0] OP_HEAD   = 3'd2;
   localparam logic [2:0] OP_LOWEST = 3'd3;
   localparam logic [2:0] OP_ALL    = 3'd4;

   // Datapath command codes.
   localparam logic [3:0] DP_NOP       = 4'd0;
   localparam logic [3:0] DP_LOAD      = 4'd1;
   localparam logic [3:0] DP_WALK      = 4'd2;
   localparam logic [3:0] DP_INSERT    = 4'd3;
   localparam logic [3:0] DP_REM_SHIFT = 4'd4;
   localparam logic [3:0] DP_REM_FOLD  = 4'd5;
   localparam logic [3:0] DP_SCAN      = 4'd6;
   localparam logic [3:0] DP_SCAN_END  = 4'd7;
   localparam logic [3:0] DP_DEC       = 4'd8;
   localparam logic [3:0] DP_EMIT      = 4'd9;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic [3:0] code;
      logic       woke;
      logic       last;
      logic       rej;
   } sdq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic walk_go;
      logic scan_done;
      logic head_zero;
   } sdq_status_type;

endpackage

[design/sdq_datapath.sv]
// Entry store, walk and search registers, and result registers of the queue.
`timescale 1ns / 1ps
module sdq_datapath #(
   parameter int CAPACITY    = 16,
   parameter int ID_WIDTH    = 16,
   parameter int DELAY_WIDTH = 32,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdq_pkg::sdq_cmd_type   cmd,
   output sdq_pkg::sdq_status_type status,
   input  logic [ID_WIDTH-1:0]    req_thread_id,
   input  logic [DELAY_WIDTH-1:0] req_delay,
   output logic                   rsp_valid,
   output logic                   rsp_woke,
   output logic [ID_WIDTH-1:0]    rsp_woken_id,
   output logic                   rsp_last,
   output logic [ID_WIDTH-1:0]    rsp_min_sleeping_id,
   output logic [CW-1:0]          rsp_sleepers,
   output logic                   rsp_rejected
);
   import sdq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Entry store, head at index zero.
   logic [ID_WIDTH-1:0]    ids_ff [CAPACITY];
   logic [ID_WIDTH-1:0]    ids_in [CAPACITY];
   logic [DELAY_WIDTH-1:0] dls_ff [CAPACITY];
   logic [DELAY_WIDTH-1:0] dls_in [CAPACITY];
   logic [CW-1:0]          count_ff, count_in;

   // Working registers.
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          best_ff, best_in;
   logic [ID_WIDTH-1:0]    tid_ff, tid_in;
   logic [DELAY_WIDTH-1:0] rel_ff, rel_in;
   logic [ID_WIDTH-1:0]    srch_ff, srch_in;
   logic [ID_WIDTH-1:0]    min_ff, min_in;
   logic [ID_WIDTH-1:0]    wid_ff, wid_in;
   logic [DELAY_WIDTH-1:0] wdl_ff, wdl_in;

   // Result registers.
   logic                   valid_ff;
   logic                   woke_ff;
   logic [ID_WIDTH-1:0]    woken_ff;
   logic                   last_ff;
   logic [ID_WIDTH-1:0]    rmin_ff;
   logic [CW-1:0]          rcnt_ff;
   logic                   rej_ff;

   // Single read port at the walk index.
   logic [ID_WIDTH-1:0]    rd_id;
   logic [DELAY_WIDTH-1:0] rd_dl;
   logic [DELAY_WIDTH:0]   fold_sum;

   assign rd_id    = ids_ff[idx_ff[AW-1:0]];
   assign rd_dl    = dls_ff[idx_ff[AW-1:0]];
   assign fold_sum = {1'b0, rd_dl} + {1'b0, wdl_ff};

   // Status toward the controller.
   assign status.full      = (count_ff == CW'(CAPACITY));
   assign status.empty     = (count_ff == '0);
   assign status.walk_go   = (idx_ff < count_ff) && (rel_ff >= rd_dl);
   assign status.scan_done = (idx_ff >= count_ff);
   assign status.head_zero = (count_ff != '0) && (dls_ff[0] == '0);

   // Next-state logic for the store and working registers.
   always_comb begin
      ids_in   = ids_ff;
      dls_in   = dls_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      tid_in   = tid_ff;
      rel_in   = rel_ff;
      srch_in  = srch_ff;
      min_in   = min_ff;
      wid_in   = wid_ff;
      wdl_in   = wdl_ff;
      case (cmd.code)
         DP_LOAD: begin
            tid_in  = req_thread_id;
            rel_in  = req_delay;
            idx_in  = '0;
            srch_in = '1;
            best_in = '0;
         end
         DP_WALK: begin
            rel_in = rel_ff - rd_dl;
            idx_in = idx_ff + CW'(1);
         end
         DP_INSERT: begin
            // Open a gap at the index; the old entry there gives up the new delay.
            for (int i = 1; i < CAPACITY; i++) begin
               if (CW'(i) > idx_ff) begin
                  ids_in[i] = ids_ff[i-1];
                  if (CW'(i) == idx_ff + CW'(1)) begin
                     dls_in[i] = rd_dl - rel_ff;
                  end else begin
                     dls_in[i] = dls_ff[i-1];
                  end
               end
            end
            for (int i = 0; i < CAPACITY; i++) begin
               if (CW'(i) == idx_ff) begin
                  ids_in[i] = tid_ff;
                  dls_in[i] = rel_ff;
               end
            end
            count_in = count_ff + CW'(1);
            idx_in   = '0;
            srch_in  = '1;
            best_in  = '0;
         end
         DP_REM_SHIFT: begin
            wid_in = rd_id;
            wdl_in = rd_dl;
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (CW'(i) >= idx_ff) begin
                  ids_in[i] = ids_ff[i+1];
                  dls_in[i] = dls_ff[i+1];
               end
            end
            count_in = count_ff - CW'(1);
         end
         DP_REM_FOLD: begin
            // The successor now at the index takes the removed delta, saturating.
            if (idx_ff < count_ff) begin
               dls_in[idx_ff[AW-1:0]] = fold_sum[DELAY_WIDTH] ? '1 :
                                        fold_sum[DELAY_WIDTH-1:0];
            end
            idx_in  = '0;
            srch_in = '1;
            best_in = '0;
         end
         DP_SCAN: begin
            if (idx_ff < count_ff) begin
               if (rd_id < srch_ff) begin
                  srch_in = rd_id;
                  best_in = idx_ff;
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         DP_SCAN_END: begin
            min_in = srch_ff;
            idx_in = best_ff;
         end
         DP_DEC: begin
            if (count_ff != '0 && dls_ff[0] != '0) begin
               dls_in[0] = dls_ff[0] - DELAY_WIDTH'(1);
            end
         end
         DP_EMIT: begin
            idx_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '1;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         valid_ff <= (cmd.code == DP_EMIT);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ids_ff  <= ids_in;
      dls_ff  <= dls_in;
      idx_ff  <= idx_in;
      best_ff <= best_in;
      tid_ff  <= tid_in;
      rel_ff  <= rel_in;
      srch_ff <= srch_in;
      wid_ff  <= wid_in;
      wdl_ff  <= wdl_in;
      if (cmd.code == DP_EMIT) begin
         woke_ff  <= cmd.woke;
         woken_ff <= cmd.woke ? wid_ff : '0;
         last_ff  <= cmd.last;
         rmin_ff  <= min_ff;
         rcnt_ff  <= count_ff;
         rej_ff   <= cmd.rej;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_woke            = woke_ff;
   assign rsp_woken_id        = woken_ff;
   assign rsp_last            = last_ff;
   assign rsp_min_sleeping_id = rmin_ff;
   assign rsp_sleepers        = rcnt_ff;
   assign rsp_rejected        = rej_ff;

   // The fill count never passes the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // An insert grows the store by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.code == DP_INSERT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the store");

   // A rejected add reports a full store and wakes nothing.
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rej_ff |-> rcnt_ff == CW'(CAPACITY) && !woke_ff)
      else $error("rejection without a full store");

endmodule

[design/sdq_controller.sv]
// Sequencing state machine that drives the queue datapath.
`timescale 1ns / 1ps
module sdq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              req_op,
   output logic                    busy,
   output sdq_pkg::sdq_cmd_type    cmd,
   input  sdq_pkg::sdq_status_type status
);
   import sdq_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WALK  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_SCANB = 4'd4;
   localparam logic [3:0] S_REM1  = 4'd5;
   localparam logic [3:0] S_REM2  = 4'd6;
   localparam logic [3:0] S_SCANM = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       woke_ff, woke_in;
   logic       rej_ff, rej_in;
   logic       emit_last;

   // The last result of a transaction depends on what remains to wake.
   always_comb begin
      case (op_ff)
         OP_TICK: emit_last = !(woke_ff && status.head_zero);
         OP_ALL:  emit_last = !woke_ff || status.empty;
         default: emit_last = 1'b1;
      endcase
   end

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      woke_in  = woke_ff;
      rej_in   = rej_ff;
      cmd      = '{code: DP_NOP, woke: 1'b0, last: 1'b0, rej: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.code = DP_LOAD;
               op_in    = req_op;
               woke_in  = 1'b0;
               rej_in   = 1'b0;
               case (req_op)
                  OP_ADD: begin
                     if (status.full) begin
                        rej_in   = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_TICK:   state_in = S_DEC;
                  OP_HEAD:   state_in = status.empty ? S_EMIT : S_REM1;
                  OP_LOWEST: state_in = status.empty ? S_EMIT : S_SCANB;
                  OP_ALL:    state_in = status.empty ? S_EMIT : S_REM1;
                  default:   state_in = S_EMIT;
               endcase
            end
         end
         S_WALK: begin
            if (status.walk_go) begin
               cmd.code = DP_WALK;
            end else begin
               cmd.code = DP_INSERT;
               state_in = S_SCANM;
            end
         end
         S_DEC: begin
            cmd.code = DP_DEC;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = status.head_zero ? S_REM1 : S_EMIT;
         end
         S_SCANB: begin
            if (status.scan_done) begin
               cmd.code = DP_SCAN_END;
               state_in = S_REM1;
            end else begin
               cmd.code = DP_SCAN;
            end
         end
         S_REM1: begin
            cmd.code = DP_REM_SHIFT;
            woke_in  = 1'b1;
            state_in = S_REM2;
         end
         S_REM2: begin
            cmd.code = DP_REM_FOLD;
            state_in = S_SCANM;
         end
         S_SCANM: begin
            if (status.scan_done) begin
               cmd.code = DP_SCAN_END;
               state_in = S_EMIT;
            end else begin
               cmd.code = DP_SCAN;
            end
         end
         S_EMIT: begin
            cmd.code = DP_EMIT;
            cmd.woke = woke_ff;
            cmd.last = emit_last;
            cmd.rej  = rej_ff;
            state_in = emit_last ? S_IDLE : S_REM1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         woke_ff  <= 1'b0;
         rej_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         woke_ff  <= woke_in;
         rej_ff   <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign busy = (state_ff != S_IDLE);

   // A wake result is issued only after an entry was removed.
   a_emit_woke: assert property (@(posedge clock) disable iff (reset)
      cmd.code == DP_EMIT && cmd.woke |-> woke_ff && !rej_ff)
      else $error("wake result without removal");

   // Removal is always followed by the delta fold.
   a_rem_fold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REM1 |=> state_ff == S_REM2)
      else $error("removal not followed by fold");

   // A new transaction is only taken from idle.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.code == DP_LOAD |-> !busy && start)
      else $error("load outside idle");

endmodule

[design/sleep_delta_queue_unit.sv]
// Top level of the sleep delta queue: controller and datapath.
`timescale 1ns / 1ps
// A delta-list timer queue of sleeping thread ids. A transaction is taken when
// start is high and busy is low; busy stays high until the last result of it
// has been issued. Each result appears for one cycle with rsp_valid and cannot
// be held off; rsp_last marks the final result of a transaction. Walk and
// scan reads go through one read port at a walk index, so the walk and the
// scan cover one entry per cycle. A rejected add, an unused op or a removal
// from an empty store goes straight to its result. A tick that wakes nothing
// decrements the head delay and checks it. An add walks past the entries
// whose deltas fit in its delay, inserts, then scans for the lowest id.
// Wake-head removes the head, folds its delta into the successor and scans.
// Each further entry woken by a tick or by wake-all is removed and folded
// after the previous result, and the store is scanned anew. A tick first
// decrements and checks; wake-lowest-id first scans for the lowest id.
module sleep_delta_queue_unit #(
   parameter int CAPACITY    = sdq_pkg::DEF_CAPACITY,
   parameter int ID_WIDTH    = sdq_pkg::DEF_ID_WIDTH,
   parameter int DELAY_WIDTH = sdq_pkg::DEF_DELAY_WIDTH,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_op,
   input  logic [ID_WIDTH-1:0]    req_thread_id,
   input  logic [DELAY_WIDTH-1:0] req_delay,
   output logic                   rsp_valid,
   output logic                   rsp_woke,
   output logic [ID_WIDTH-1:0]    rsp_woken_id,
   output logic                   rsp_last,
   output logic [ID_WIDTH-1:0]    rsp_min_sleeping_id,
   output logic [CW-1:0]          rsp_sleepers,
   output logic                   rsp_rejected
);
   import sdq_pkg::*;

   sdq_cmd_type    cmd;
   sdq_status_type status;

   // Sequencer.
   sdq_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Store and result registers.
   sdq_datapath #(
      .CAPACITY    (CAPACITY),
      .ID_WIDTH    (ID_WIDTH),
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_thread_id       (req_thread_id),
      .req_delay           (req_delay),
      .rsp_valid           (rsp_valid),
      .rsp_woke            (rsp_woke),
      .rsp_woken_id        (rsp_woken_id),
      .rsp_last            (rsp_last),
      .rsp_min_sleeping_id (rsp_min_sleeping_id),
      .rsp_sleepers        (rsp_sleepers),
      .rsp_rejected        (rsp_rejected)
   );

endmodule
